// ----- src/upi_pkg.sv -----
// Shared types and constants for the unicycle pose integrator.
package upi_pkg;

  // Field and datapath widths.
  localparam int ANG_W  = 32;
  localparam int POS_W  = 32;
  localparam int DT_W   = 24;
  localparam int TRIG_W = 34;
  localparam int MUL_W  = 33;
  localparam int PROD_W = 2 * MUL_W;

  // Step time after reset: one second in Q8.16.
  localparam logic [DT_W-1:0] STEP_TIME_RST = 24'd65536;

  // CORDIC start vector (gain compensation) and unity, both Q2.30.
  localparam logic signed [TRIG_W-1:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic [30:0]              ONE_Q30     = 31'd1073741824;

  // Arctangent of 2^-i in binary-angle units, full turn = 2^32.
  localparam int ATAN_N = 32;
  localparam logic [31:0] ATAN_TAB [ATAN_N] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861,
    32'd10430,     32'd5215,      32'd2608,      32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81,
    32'd41,        32'd20,        32'd10,        32'd5,
    32'd3,         32'd1,         32'd1,         32'd0
  };

  // Result of one cosine/sine evaluation; valid pulses for one cycle.
  typedef struct packed {
    logic                     valid;
    logic signed [TRIG_W-1:0] cos_v;
    logic signed [TRIG_W-1:0] sin_v;
  } trig_res_t;

endpackage

// ----- src/upi_cordic.sv -----
// Iterative rotation-mode CORDIC giving cosine and sine of a binary angle.
module upi_cordic
  import upi_pkg::*;
#(
  parameter int unsigned STEPS = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [ANG_W-1:0] angle,
  output trig_res_t        res
);

  localparam int CNT_W = $clog2(STEPS);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(STEPS - 1);

  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;
  localparam logic [1:0] QUAD_3 = 2'd3;

  logic                     busy_r, busy_nxt;
  logic                     map_r, map_nxt;
  logic                     valid_r, valid_nxt;
  logic [CNT_W-1:0]         cnt_r, cnt_nxt;
  logic [1:0]               quad_r;
  logic signed [TRIG_W-1:0] x_r, y_r, z_r;
  logic signed [TRIG_W-1:0] cos_r, sin_r;

  logic [ANG_W-1:0]         ang_bias;
  logic [1:0]               quad;
  logic [ANG_W-1:0]         resid;
  logic [4:0]               idx;
  logic signed [TRIG_W-1:0] dx, dy, atan_s;
  logic signed [TRIG_W-1:0] x_step, y_step, z_step;
  logic signed [TRIG_W-1:0] cos_map, sin_map;

  // Quadrant reduction: residual lies in [-1/8, 1/8) of a turn.
  always_comb begin
    ang_bias = angle + 32'h2000_0000;
    quad     = ang_bias[ANG_W-1:ANG_W-2];
    resid    = angle - {quad, 30'd0};
  end

  // One micro-rotation per cycle.
  always_comb begin
    idx    = 5'(cnt_r);
    dx     = y_r >>> cnt_r;
    dy     = x_r >>> cnt_r;
    atan_s = $signed({{(TRIG_W-32){1'b0}}, ATAN_TAB[idx]});
    if (!z_r[TRIG_W-1]) begin
      x_step = x_r - dx;
      y_step = y_r + dy;
      z_step = z_r - atan_s;
    end else begin
      x_step = x_r + dx;
      y_step = y_r - dy;
      z_step = z_r + atan_s;
    end
  end

  // Rotate the result back into the original quadrant.
  always_comb begin
    unique case (quad_r)
      QUAD_0: begin
        cos_map = x_r;
        sin_map = y_r;
      end
      QUAD_1: begin
        cos_map = -y_r;
        sin_map = x_r;
      end
      QUAD_2: begin
        cos_map = -x_r;
        sin_map = -y_r;
      end
      QUAD_3: begin
        cos_map = y_r;
        sin_map = -x_r;
      end
      default: begin
        cos_map = x_r;
        sin_map = y_r;
      end
    endcase
  end

  // Sequencing of the iterations.
  always_comb begin
    map_nxt   = busy_r && (cnt_r == LAST);
    valid_nxt = map_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
    end else if (busy_r) begin
      busy_nxt = (cnt_r != LAST);
      cnt_nxt  = cnt_r + CNT_W'(1);
    end else begin
      busy_nxt = 1'b0;
      cnt_nxt  = cnt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      map_r   <= 1'b0;
      valid_r <= 1'b0;
      cnt_r   <= '0;
    end else begin
      busy_r  <= busy_nxt;
      map_r   <= map_nxt;
      valid_r <= valid_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // Vector and angle registers.
  always_ff @(posedge clk) begin
    if (start) begin
      x_r    <= CORDIC_GAIN;
      y_r    <= '0;
      z_r    <= $signed({{(TRIG_W-ANG_W){resid[ANG_W-1]}}, resid});
      quad_r <= quad;
    end else if (busy_r) begin
      x_r <= x_step;
      y_r <= y_step;
      z_r <= z_step;
    end
    if (map_r) begin
      cos_r <= cos_map;
      sin_r <= sin_map;
    end
  end

  assign res.valid = valid_r;
  assign res.cos_v = cos_r;
  assign res.sin_v = sin_r;

endmodule

// ----- src/upi_mult.sv -----
// Shared signed multiplier with a registered product.
module upi_mult
  import upi_pkg::*;
(
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [MUL_W-1:0] a,
  input  logic signed [MUL_W-1:0] b,
  output logic signed [PROD_W-1:0] p_r
);

  // The product holds while the unit is not in use.
  always_ff @(posedge clk) begin
    if (en) begin
      p_r <= a * b;
    end
  end

endmodule

// ----- src/unicycle_pose_integrator.sv -----
// Top level of the unicycle pose integrator: sequencer, pose state and outputs.
//
// Each accepted beat moves the stored pose by one forward-Euler step and
// yields one result beat; in_ready returns in the same cycle as that beat,
// and no new item is taken while one is in flight. The processing time is
// set by the CORDIC, which does one micro-rotation per cycle, followed by
// four passes through the single shared 33x33 multiplier for the x and y
// displacements (the distance and heading products run while the CORDIC
// iterates). A new item is accepted while the previous result still waits
// on out_ready; the result is held until the output register is free.
// step_time may only be written while no item is in flight.
module unicycle_pose_integrator
  import upi_pkg::*;
#(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic [DT_W-1:0]         cfg_wdata,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    in_start_req,
  input  logic signed [POS_W-1:0] in_start_x,
  input  logic signed [POS_W-1:0] in_start_y,
  input  logic [ANG_W-1:0]        in_start_heading,
  input  logic signed [31:0]      in_speed,
  input  logic signed [31:0]      in_turn_rate,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [POS_W-1:0] out_pos_x,
  output logic signed [POS_W-1:0] out_pos_y,
  output logic [ANG_W-1:0]        out_heading,
  output logic                    out_saturated
);

  localparam int RND_W = 41;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DIST = 4'd1;
  localparam logic [3:0] S_TURN = 4'd2;
  localparam logic [3:0] S_WAIT = 4'd3;
  localparam logic [3:0] S_XL   = 4'd4;
  localparam logic [3:0] S_XH   = 4'd5;
  localparam logic [3:0] S_YL   = 4'd6;
  localparam logic [3:0] S_YH   = 4'd7;
  localparam logic [3:0] S_SUM  = 4'd8;
  localparam logic [3:0] S_FIN  = 4'd9;

  logic [3:0]              state_r, state_nxt;
  logic [DT_W-1:0]         step_time_r;
  logic signed [POS_W-1:0] pose_x_r, pose_y_r;
  logic [ANG_W-1:0]        pose_h_r;
  logic signed [31:0]      v_r, w_r;
  logic                    dist_neg_r;
  logic [54:0]             dist_mag_r;
  logic [ANG_W-1:0]        dh_r;
  logic [30:0]             cmx_r, cmy_r;
  logic                    negx_r, negy_r;
  logic [62:0]             lo_r;
  logic [RND_W-1:0]        rx_r, ry_r;
  logic                    out_valid_r, out_valid_nxt;
  logic signed [POS_W-1:0] out_pos_x_r, out_pos_y_r;
  logic [ANG_W-1:0]        out_heading_r;
  logic                    out_sat_r;

  logic                     in_acc;
  logic                     commit;
  logic [ANG_W-1:0]         trig_angle;
  trig_res_t                trig_res;
  logic                     mul_en;
  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] prod;
  logic [55:0]              dist_abs;
  logic [POS_W:0]           sat_x, sat_y;

  // Magnitude of a CORDIC output, clipped to unity.
  function automatic logic [30:0] trig_mag(input logic signed [TRIG_W-1:0] t);
    logic [TRIG_W-1:0] m;
    m = t[TRIG_W-1] ? TRIG_W'(-t) : TRIG_W'(t);
    if (m > {{(TRIG_W-31){1'b0}}, ONE_Q30}) begin
      return ONE_Q30;
    end
    return m[30:0];
  endfunction

  // Combine the two partial products and round to nearest at 2^-46.
  function automatic logic [RND_W-1:0] round_move(input logic [53:0] hi,
                                                  input logic [62:0] lo);
    logic [63:0] sum;
    logic [54:0] top;
    sum = {1'b0, lo} + (64'd1 << 45);
    top = {1'b0, hi} + {23'd0, sum[63:32]};
    return top[54:14];
  endfunction

  // Saturating add of a signed displacement; the top bit flags clipping.
  function automatic logic [POS_W:0] sat_move(input logic [POS_W-1:0] p,
                                              input logic [RND_W-1:0] r,
                                              input logic neg);
    logic signed [RND_W+1:0] d;
    logic signed [RND_W+1:0] s;
    d = neg ? -$signed({2'b00, r}) : $signed({2'b00, r});
    s = $signed({{(RND_W+2-POS_W){p[POS_W-1]}}, p}) + d;
    if (s[RND_W+1:POS_W-1] == {(RND_W+3-POS_W){s[RND_W+1]}}) begin
      return {1'b0, s[POS_W-1:0]};
    end else if (s[RND_W+1]) begin
      return {1'b1, 32'h8000_0000};
    end
    return {1'b1, 32'h7FFF_FFFF};
  endfunction

  assign in_ready = (state_r == S_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign commit   = (state_r == S_FIN) && (!out_valid_r || out_ready);

  // Cosine and sine of the heading before the step.
  assign trig_angle = in_start_req ? in_start_heading : pose_h_r;

  upi_cordic #(
    .STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (in_acc),
    .angle (trig_angle),
    .res   (trig_res)
  );

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_en = 1'b1;
    mul_a  = '0;
    mul_b  = '0;
    unique case (state_r)
      S_DIST: begin
        mul_a = $signed({9'd0, step_time_r});
        mul_b = $signed({v_r[31], v_r});
      end
      S_TURN: begin
        mul_a = $signed({9'd0, step_time_r});
        mul_b = $signed({w_r[31], w_r});
      end
      S_XL: begin
        mul_a = $signed({1'b0, dist_mag_r[31:0]});
        mul_b = $signed({2'b00, cmx_r});
      end
      S_XH: begin
        mul_a = $signed({10'd0, dist_mag_r[54:32]});
        mul_b = $signed({2'b00, cmx_r});
      end
      S_YL: begin
        mul_a = $signed({1'b0, dist_mag_r[31:0]});
        mul_b = $signed({2'b00, cmy_r});
      end
      S_YH: begin
        mul_a = $signed({10'd0, dist_mag_r[54:32]});
        mul_b = $signed({2'b00, cmy_r});
      end
      default: begin
        mul_en = 1'b0;
      end
    endcase
  end

  upi_mult u_mult (
    .clk (clk),
    .en  (mul_en),
    .a   (mul_a),
    .b   (mul_b),
    .p_r (prod)
  );

  // Distance magnitude; the product of step time and speed fits 56 bits.
  assign dist_abs = prod[55] ? (~prod[55:0] + 56'd1) : prod[55:0];

  assign sat_x = sat_move(pose_x_r, rx_r, negx_r);
  assign sat_y = sat_move(pose_y_r, ry_r, negy_r);

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_acc) state_nxt = S_DIST;
      S_DIST: state_nxt = S_TURN;
      S_TURN: state_nxt = S_WAIT;
      S_WAIT: if (trig_res.valid) state_nxt = S_XL;
      S_XL:   state_nxt = S_XH;
      S_XH:   state_nxt = S_YL;
      S_YL:   state_nxt = S_YH;
      S_YH:   state_nxt = S_SUM;
      S_SUM:  state_nxt = S_FIN;
      S_FIN:  if (commit) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Output beat handshake.
  always_comb begin
    if (commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // Control state, step time and the stored pose.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      step_time_r <= STEP_TIME_RST;
      pose_x_r    <= '0;
      pose_y_r    <= '0;
      pose_h_r    <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        step_time_r <= cfg_wdata;
      end
      if (in_acc && in_start_req) begin
        pose_x_r <= in_start_x;
        pose_y_r <= in_start_y;
        pose_h_r <= in_start_heading;
      end else if (commit) begin
        pose_x_r <= $signed(sat_x[POS_W-1:0]);
        pose_y_r <= $signed(sat_y[POS_W-1:0]);
        pose_h_r <= pose_h_r + dh_r;
      end
    end
  end

  // Working registers of the step.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      v_r <= in_speed;
      w_r <= in_turn_rate;
    end
    if (state_r == S_TURN) begin
      dist_neg_r <= prod[PROD_W-1];
      dist_mag_r <= dist_abs[54:0];
    end
    if (state_r == S_WAIT) begin
      dh_r <= prod[ANG_W-1:0];
      if (trig_res.valid) begin
        cmx_r  <= trig_mag(trig_res.cos_v);
        cmy_r  <= trig_mag(trig_res.sin_v);
        negx_r <= dist_neg_r ^ trig_res.cos_v[TRIG_W-1];
        negy_r <= dist_neg_r ^ trig_res.sin_v[TRIG_W-1];
      end
    end
    if ((state_r == S_XH) || (state_r == S_YH)) begin
      lo_r <= prod[62:0];
    end
    if (state_r == S_YL) begin
      rx_r <= round_move(prod[53:0], lo_r);
    end
    if (state_r == S_SUM) begin
      ry_r <= round_move(prod[53:0], lo_r);
    end
    if (commit) begin
      out_pos_x_r   <= $signed(sat_x[POS_W-1:0]);
      out_pos_y_r   <= $signed(sat_y[POS_W-1:0]);
      out_heading_r <= pose_h_r + dh_r;
      out_sat_r     <= sat_x[POS_W] | sat_y[POS_W];
    end
  end

  assign out_valid     = out_valid_r;
  assign out_pos_x     = out_pos_x_r;
  assign out_pos_y     = out_pos_y_r;
  assign out_heading   = out_heading_r;
  assign out_saturated = out_sat_r;

endmodule

// ----- src/upi_checker.sv -----
// Port-level checks for the unicycle pose integrator, bound to the top level.
module upi_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_pos_x,
  input logic [31:0] out_pos_y,
  input logic [31:0] out_heading,
  input logic        out_saturated
);

  logic       in_acc, out_acc;
  logic [1:0] pend_r;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // Items accepted whose result beat has not yet been taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 2'd0;
    end else if (in_acc && !out_acc) begin
      pend_r <= pend_r + 2'd1;
    end else if (out_acc && !in_acc) begin
      pend_r <= pend_r - 2'd1;
    end
  end

  // One item at a time: ready drops straight after an accepted beat.
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_ready)
    else $error("in_ready stayed high after an accepted input beat");

  // No result beat without an item behind it.
  a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (pend_r != 2'd0))
    else $error("result beat shown with no item outstanding");

  // At most one undelivered result when a new item is taken.
  a_backlog: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> ((pend_r == 2'd0) || (pend_r == 2'd1)))
    else $error("input accepted while two results were outstanding");

  // A clipped step leaves a coordinate at a range limit.
  a_sat_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_saturated) |->
      ((out_pos_x == 32'h7FFF_FFFF) || (out_pos_x == 32'h8000_0000) ||
       (out_pos_y == 32'h7FFF_FFFF) || (out_pos_y == 32'h8000_0000)))
    else $error("saturated flag set with neither coordinate at a limit");

  // A stalled result beat holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_pos_x) && $stable(out_pos_y) &&
       $stable(out_heading) && $stable(out_saturated)))
    else $error("stalled result beat changed");

endmodule

bind unicycle_pose_integrator upi_checker u_upi_checker (.*);

// ----- sim/tb.sv -----
// Self-checking testbench for the unicycle pose integrator, with a bit-exact pose predictor.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned STEPS       = 16;
  localparam int unsigned LIMIT_CYCLES = 400000;
  localparam int unsigned SETTLE      = STEPS + 12;
  localparam int unsigned PHASE_MOVES = 50;

  localparam longint POS_MAX  = 64'sd2147483647;
  localparam longint POS_MIN  = -64'sd2147483648;
  localparam longint GAIN_Q30 = 64'sd652032874;
  localparam longint UNIT_Q30 = 64'sd1073741824;

  // Arctangent of 2^-i as a binary angle, full turn = 2^32.
  localparam longint BAM_ATAN [32] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
    41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
    10, 5, 3, 1, 1, 0
  };

  typedef struct {
    bit               start_req;
    bit signed [31:0] start_x;
    bit signed [31:0] start_y;
    bit [31:0]        start_heading;
    bit signed [31:0] speed;
    bit signed [31:0] turn_rate;
  } move_t;

  typedef struct {
    bit [31:0] pos_x;
    bit [31:0] pos_y;
    bit [31:0] heading;
    bit        saturated;
  } pose_t;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          cfg_we = 1'b0;
  logic [upi_pkg::DT_W-1:0]      cfg_wdata = '0;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic                          in_start_req = 1'b0;
  logic signed [31:0]            in_start_x = '0;
  logic signed [31:0]            in_start_y = '0;
  logic [31:0]                   in_start_heading = '0;
  logic signed [31:0]            in_speed = '0;
  logic signed [31:0]            in_turn_rate = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic signed [31:0]            out_pos_x;
  logic signed [31:0]            out_pos_y;
  logic [31:0]                   out_heading;
  logic                          out_saturated;

  unicycle_pose_integrator #(
    .CORDIC_STEPS(STEPS)
  ) i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_start_req    (in_start_req),
    .in_start_x      (in_start_x),
    .in_start_y      (in_start_y),
    .in_start_heading(in_start_heading),
    .in_speed        (in_speed),
    .in_turn_rate    (in_turn_rate),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_pos_x       (out_pos_x),
    .out_pos_y       (out_pos_y),
    .out_heading     (out_heading),
    .out_saturated   (out_saturated)
  );

  // Predicted pose and step time, tracking the block.
  longint    mdl_x = 0;
  longint    mdl_y = 0;
  bit [31:0] mdl_hd = '0;
  bit [23:0] dt_now = 24'd65536;

  move_t pending_moves [$];
  pose_t expected_poses [$];
  move_t cur_move;

  int unsigned tx_max_gap = 18;
  int unsigned rx_max_stall = 18;
  int unsigned gap_left = 0;
  int unsigned stall_left = 0;
  int unsigned errors = 0;
  int unsigned moves_queued = 0;
  int unsigned moves_taken = 0;
  int unsigned poses_checked = 0;
  int unsigned dt_settings = 0;
  int unsigned saturations = 0;
  int unsigned cycles = 0;

  // Cosine and sine of a binary angle in Q2.30, by quadrant folding and CORDIC.
  function automatic void unit_vector(input bit [31:0] ang, output longint cs,
                                      output longint sn);
    bit [32:0] folded;
    bit [1:0]  quad;
    bit [31:0] resid;
    int        resid_s;
    longint    z, vx, vy, dx, dy;
    folded  = {1'b0, ang} + 33'h0_2000_0000;
    quad    = folded[31:30];
    resid   = ang - {quad, 30'd0};
    resid_s = resid;
    z       = resid_s;
    vx      = GAIN_Q30;
    vy      = 0;
    for (int i = 0; i < STEPS && i < 32; i++) begin
      dx = vy >>> i;
      dy = vx >>> i;
      if (z >= 0) begin
        vx = vx - dx;
        vy = vy + dy;
        z  = z - BAM_ATAN[i];
      end else begin
        vx = vx + dx;
        vy = vy - dy;
        z  = z + BAM_ATAN[i];
      end
    end
    case (quad)
      2'd0: begin cs = vx;  sn = vy;  end
      2'd1: begin cs = -vy; sn = vx;  end
      2'd2: begin cs = -vx; sn = -vy; end
      default: begin cs = vy; sn = -vx; end
    endcase
  endfunction

  // Displacement in Q16.16 from a distance at scale 2^32 and a Q2.30 factor,
  // rounded to nearest with ties away from zero.
  function automatic longint displace(input longint travel, input longint unitv);
    bit         neg;
    bit [63:0]  mag;
    bit [63:0]  cf;
    bit [127:0] prod;
    neg  = (travel < 0) != (unitv < 0);
    mag  = (travel < 0) ? -travel : travel;
    cf   = (unitv < 0) ? -unitv : unitv;
    if (cf > UNIT_Q30) cf = UNIT_Q30;
    prod = (128'(mag) * 128'(cf) + (128'd1 << 45)) >> 46;
    return neg ? -longint'(prod[63:0]) : longint'(prod[63:0]);
  endfunction

  function automatic longint clip_add(input longint a, input longint d, inout bit hit);
    longint s;
    s = a + d;
    if (s > POS_MAX) begin
      hit = 1'b1;
      return POS_MAX;
    end
    if (s < POS_MIN) begin
      hit = 1'b1;
      return POS_MIN;
    end
    return s;
  endfunction

  // One Euler step of the predicted pose; returns the pose the block should emit.
  function automatic pose_t advance_pose(input move_t m);
    longint cs, sn, dtl, travel, dh;
    bit     hit;
    pose_t  r;
    if (m.start_req) begin
      mdl_x  = m.start_x;
      mdl_y  = m.start_y;
      mdl_hd = m.start_heading;
    end
    unit_vector(mdl_hd, cs, sn);
    dtl    = longint'(dt_now);
    travel = dtl * m.speed;
    dh     = dtl * m.turn_rate;
    hit    = 1'b0;
    mdl_x  = clip_add(mdl_x, displace(travel, cs), hit);
    mdl_y  = clip_add(mdl_y, displace(travel, sn), hit);
    mdl_hd = mdl_hd + dh[31:0];
    r.pos_x     = mdl_x[31:0];
    r.pos_y     = mdl_y[31:0];
    r.heading   = mdl_hd;
    r.saturated = hit;
    return r;
  endfunction

  // A mix of full-range words, the two extremes and small signed values.
  function automatic bit [31:0] pick_word();
    bit [31:0] w;
    case ($urandom_range(0, 9))
      0: w = 32'h8000_0000;
      1: w = 32'h7FFF_FFFF;
      2, 3, 4: w = $urandom();
      default: w = $urandom_range(0, 32'h7FFFF) - 32'h40000;
    endcase
    return w;
  endfunction

  task automatic queue_move(input bit req, input bit [31:0] sx, input bit [31:0] sy,
                            input bit [31:0] sh, input bit [31:0] v, input bit [31:0] w);
    move_t m;
    m.start_req     = req;
    m.start_x       = sx;
    m.start_y       = sy;
    m.start_heading = sh;
    m.speed         = v;
    m.turn_rate     = w;
    pending_moves = {pending_moves, m};
    moves_queued++;
  endtask

  // Random moves: mostly continued trajectories, with a fresh start now and then.
  task automatic queue_random_moves(input int unsigned n);
    for (int unsigned k = 0; k < n; k++) begin
      queue_move($urandom_range(0, 7) == 0, pick_word(), pick_word(), $urandom(),
                 pick_word(), pick_word());
    end
  endtask

  // Wait until every queued move has had its result beat checked, then idle a while.
  task automatic drain();
    do @(posedge clk);
    while (poses_checked != moves_queued);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_step_time(input bit [23:0] v);
    @(posedge clk);
    cfg_wdata <= v;
    cfg_we    <= 1'b1;
    dt_now     = v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    dt_settings++;
  endtask

  task automatic cmp_field(input string name, input logic [31:0] want,
                           input logic [31:0] got);
    if (got !== want) begin
      errors++;
      if (errors <= 40)
        $display("%0t ns: %s mismatch, expected %h, got %h", $time, name, want, got);
    end
  endtask

  initial begin
    forever #5 clk = ~clk;
  end

  // Input side: present queued moves with a random gap before each beat.
  always @(posedge clk) begin : drive_moves
    bit    nxt_valid;
    pose_t nxt_pose;
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else begin
      nxt_valid = in_valid;
      if (in_valid && in_ready) begin
        nxt_pose       = advance_pose(cur_move);
        expected_poses = {expected_poses, nxt_pose};
        moves_taken++;
        nxt_valid = 1'b0;
      end
      if (!nxt_valid) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
        end else if (pending_moves.size() != 0) begin
          cur_move          = pending_moves.pop_front();
          in_start_req     <= cur_move.start_req;
          in_start_x       <= cur_move.start_x;
          in_start_y       <= cur_move.start_y;
          in_start_heading <= cur_move.start_heading;
          in_speed         <= cur_move.speed;
          in_turn_rate     <= cur_move.turn_rate;
          gap_left         <= $urandom_range(0, tx_max_gap);
          nxt_valid         = 1'b1;
        end
      end
      in_valid <= nxt_valid;
    end
  end

  // Result side: check each beat against the oldest prediction, stall at random.
  always @(posedge clk) begin : check_poses
    pose_t       want;
    int unsigned hold;
    if (!rst_n) begin
      out_ready  <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid && out_ready) begin
        poses_checked++;
        if (expected_poses.size() == 0) begin
          errors++;
          $display("%0t ns: result beat with none expected, got x=%h y=%h h=%h s=%b",
                   $time, out_pos_x, out_pos_y, out_heading, out_saturated);
        end else begin
          want = expected_poses.pop_front();
          if (want.saturated) saturations++;
          cmp_field("pos_x", want.pos_x, out_pos_x);
          cmp_field("pos_y", want.pos_y, out_pos_y);
          cmp_field("heading", want.heading, out_heading);
          cmp_field("saturated", {31'd0, want.saturated}, {31'd0, out_saturated});
        end
        hold = $urandom_range(0, rx_max_stall);
      end else if (stall_left != 0) begin
        hold = stall_left - 1;
      end else begin
        hold = 0;
      end
      stall_left <= hold;
      out_ready  <= (hold == 0);
    end
  end

  // Guard against a hung handshake.
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("%0t ns: timeout, %0d beats still expected", $time, expected_poses.size());
      $display("FAIL unicycle_pose_integrator");
      $finish;
    end
  end

  initial begin : stimulus
    bit [23:0] dt_plan [8];
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed moves at the reset step time of one second.
    queue_move(0, 0, 0, 0, 32'h0001_0000, 0);
    // A quarter turn per second turns the heading by exactly a quarter.
    queue_move(0, 0, 0, 0, 32'h0001_0000, 32'h0000_4000);
    queue_move(0, 0, 0, 0, 32'h0001_0000, 0);
    // Positions driven past each limit in turn.
    queue_move(1, 32'h7FFF_0000, 0, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    queue_move(1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
               32'h8000_0000);
    queue_move(1, 0, 32'h7FFF_FFFF, 32'h4000_0000, 32'h7FFF_FFFF, 0);
    queue_move(1, 0, 32'h8000_0000, 32'hC000_0000, 32'h7FFF_FFFF, 0);
    queue_move(1, 0, 0, 0, 32'h8000_0000, 32'hFFFF_FFFF);
    // Headings either side of the octant boundaries that the folding uses.
    queue_move(1, 0, 0, 32'h1FFF_FFFF, 32'h0001_0000, 0);
    queue_move(1, 0, 0, 32'h2000_0000, 32'h0001_0000, 0);
    queue_move(1, 0, 0, 32'h5FFF_FFFF, 32'h0001_0000, 0);
    queue_move(1, 0, 0, 32'h6000_0000, 32'h0001_0000, 0);
    queue_move(1, 0, 0, 32'hA000_0000, 32'h0001_0000, 0);
    queue_move(1, 0, 0, 32'hE000_0000, 32'h0001_0000, 0);
    queue_move(1, 0, 0, 32'hFFFF_FFFF, 32'h0001_0000, 0);
    queue_move(1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
               32'hFFFF_FFFF);
    queue_move(0, 0, 0, 0, 0, 0);
    // Start fields must be ignored without a start request.
    queue_move(0, 32'h1234_5678, 32'h8765_4321, 32'hDEAD_BEEF, 32'h0002_8000,
               32'h7FFF_FFFF);
    queue_move(0, 0, 0, 0, 32'hFFFF_0000, 32'h8000_0000);
    drain();

    // Random moves over a range of step times, extremes included.
    dt_plan = '{24'hFF_FFFF, 24'd0, 24'd1, 24'(3 * $urandom_range(1, 65536)),
                24'd65536, 24'($urandom_range(1, 24'h3_0000)), 24'h80_0000,
                24'($urandom())};
    for (int k = 0; k < 8; k++) begin
      tx_max_gap   = (k & 1) ? 0 : 18;
      rx_max_stall = (k & 2) ? 0 : 18;
      set_step_time(dt_plan[k]);
      queue_random_moves(PHASE_MOVES);
      drain();
    end

    $display("Run covered %0d moves over %0d step time settings;", moves_taken,
             dt_settings + 1);
    $display("%0d result beats checked, %0d of them saturated.", poses_checked,
             saturations);
    if (errors == 0)
      $display("PASS unicycle_pose_integrator");
    else
      $display("FAIL unicycle_pose_integrator");
    $finish;
  end

endmodule
